FILE: rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

  // width of the value fields on the ports
  localparam int unsigned ValueBits = 32;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdGt      = 4'd4,
    CmdGe      = 4'd5,
    CmdLt      = 4'd6,
    CmdLe      = 4'd7,
    CmdEq      = 4'd8,
    CmdNe      = 4'd9,
    CmdMin     = 4'd10,
    CmdMax     = 4'd11,
    CmdInc     = 4'd12,
    CmdDec     = 4'd13,
    CmdFromInt = 4'd14,
    CmdToInt   = 4'd15
  } fpa_cmd_e;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic is_div;
    logic neg;
    logic dz;
    logic cmp;
  } fpa_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/fixed_point_alu_top.sv
// channel   valid        stall        payload
// input     in_valid_i   in_stall_o   command_i, operand_a_i, operand_b_i
// output    out_valid_o  out_stall_i  result_value_o, compare_true_o, divide_by_zero_o
//
// one item a cycle while the output is not stalled; an item passes the front stages,
// the divider, one quotient bit per stage, and the output register
// every command runs the full pipeline, so results leave in order
// reset clears only the stage valid bits
// each stage holds while the stage after it is full and stalled

`default_nettype none

module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [3:0]                   command_i,
  input  wire logic signed [31:0]           operand_a_i,
  input  wire logic signed [31:0]           operand_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [31:0]                result_value_o,
  output logic                              compare_true_o,
  output logic                              divide_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned OW = (WORD_BITS < ValueBits) ? WORD_BITS : ValueBits;
  localparam int unsigned QW = OW + FRAC_BITS;

  logic          in_ready;
  logic          st_v   [QW+1];
  logic          st_rdy [QW+1];
  logic [OW-1:0] st_res [QW+1];
  fpa_ctl_t      st_ctl [QW+1];
  logic [QW-1:0] st_dq  [QW+1];
  logic [OW-1:0] st_rem [QW+1];
  logic [OW-1:0] st_dvs [QW+1];

  assign in_stall_o = !in_ready;
  assign st_rem[0]  = '0;

  // decode, multiply and the simple commands
  fpa_front #(
    .OW        (OW),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .cmd_i       (fpa_cmd_e'(command_i)),
    .a_i         (operand_a_i[OW-1:0]),
    .b_i         (operand_b_i[OW-1:0]),
    .out_valid_o (st_v[0]),
    .out_ready_i (st_rdy[0]),
    .out_res_o   (st_res[0]),
    .out_ctl_o   (st_ctl[0]),
    .out_dq_o    (st_dq[0]),
    .out_dvs_o   (st_dvs[0])
  );

  // divider, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_stage #(
      .OW (OW),
      .QW (QW)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_v[i]),
      .in_ready_o  (st_rdy[i]),
      .res_i       (st_res[i]),
      .ctl_i       (st_ctl[i]),
      .dq_i        (st_dq[i]),
      .rem_i       (st_rem[i]),
      .dvs_i       (st_dvs[i]),
      .out_valid_o (st_v[i+1]),
      .out_ready_i (st_rdy[i+1]),
      .res_o       (st_res[i+1]),
      .ctl_o       (st_ctl[i+1]),
      .dq_o        (st_dq[i+1]),
      .rem_o       (st_rem[i+1]),
      .dvs_o       (st_dvs[i+1])
    );
  end

  // sign fix-up and output register
  fpa_back #(
    .OW (OW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_v[QW]),
    .in_ready_o  (st_rdy[QW]),
    .res_i       (st_res[QW]),
    .ctl_i       (st_ctl[QW]),
    .quot_i      (st_dq[QW][OW-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .result_o    (result_value_o),
    .cmp_o       (compare_true_o),
    .dz_o        (divide_by_zero_o)
  );

  // divide by zero reports a zero value
  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_value_o == '0)
    else $error("divide by zero with nonzero result");

  // a compare reports a zero value
  a_cmp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == '0)
    else $error("compare with nonzero result");

  // compare and divide flags never together
  a_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_true_o && divide_by_zero_o))
    else $error("both flags set");

endmodule

`default_nettype wire

FILE: rtl/fpa_front.sv
`default_nettype none

module fpa_front #(
  parameter int unsigned OW        = 32,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned QW        = OW + FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire fpa_pkg::fpa_cmd_e     cmd_i,
  input  wire logic [OW-1:0]         a_i,
  input  wire logic [OW-1:0]         b_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OW-1:0]              out_res_o,
  output fpa_pkg::fpa_ctl_t          out_ctl_o,
  output logic [QW-1:0]              out_dq_o,
  output logic [OW-1:0]              out_dvs_o
);
  import fpa_pkg::*;

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  fpa_cmd_e              cmd1_q, cmd2_q;
  logic signed [OW-1:0]  a1_q, b1_q, a2_q, b2_q;
  logic [OW-1:0]         mag_a1, mag_b1, mag_a2, mag_b2_q;
  logic [2*OW-1:0]       prod_q;

  logic [OW-1:0]         res_d, res_q;
  fpa_ctl_t              ctl_d, ctl_q;
  logic [QW-1:0]         dq_q;
  logic [OW-1:0]         dvs_q;
  logic [OW-1:0]         mul_q_val, toint_val;
  logic                  lt, gt, eq;

  // ready chain, a stage takes an item when empty or draining
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: operand register
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      cmd1_q <= cmd_i;
      a1_q   <= a_i;
      b1_q   <= b_i;
    end
  end

  // stage 2: magnitudes and product
  assign mag_a1 = a1_q[OW-1] ? OW'(-a1_q) : a1_q;
  assign mag_b1 = b1_q[OW-1] ? OW'(-b1_q) : b1_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      cmd2_q   <= cmd1_q;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      mag_b2_q <= mag_b1;
      prod_q   <= (2*OW)'(mag_a1) * (2*OW)'(mag_b1);
    end
  end

  // stage 3: all commands but the divide finish here
  assign mag_a2    = a2_q[OW-1] ? OW'(-a2_q) : a2_q;
  assign mul_q_val = OW'(prod_q >> FRAC_BITS);
  assign toint_val = mag_a2 >> FRAC_BITS;
  assign lt        = a2_q < b2_q;
  assign gt        = b2_q < a2_q;
  assign eq        = a2_q == b2_q;

  always_comb begin
    res_d      = '0;
    ctl_d      = '0;
    ctl_d.neg  = a2_q[OW-1] ^ b2_q[OW-1];
    case (cmd2_q)
      CmdAdd:     res_d = OW'(a2_q + b2_q);
      CmdSub:     res_d = OW'(a2_q - b2_q);
      CmdMul:     res_d = ctl_d.neg ? OW'(-mul_q_val) : mul_q_val;
      CmdDiv: begin
        ctl_d.is_div = 1'b1;
        ctl_d.dz     = (b2_q == '0);
      end
      CmdGt:      ctl_d.cmp = gt;
      CmdGe:      ctl_d.cmp = !lt;
      CmdLt:      ctl_d.cmp = lt;
      CmdLe:      ctl_d.cmp = !gt;
      CmdEq:      ctl_d.cmp = eq;
      CmdNe:      ctl_d.cmp = !eq;
      CmdMin:     res_d = lt ? a2_q : b2_q;
      CmdMax:     res_d = gt ? a2_q : b2_q;
      CmdInc:     res_d = OW'(a2_q + OW'(1));
      CmdDec:     res_d = OW'(a2_q - OW'(1));
      CmdFromInt: res_d = OW'(a2_q << FRAC_BITS);
      CmdToInt:   res_d = a2_q[OW-1] ? OW'(-toint_val) : toint_val;
      default:    res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res_d;
      ctl_q <= ctl_d;
      dq_q  <= QW'(mag_a2) << FRAC_BITS;
      dvs_q <= mag_b2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_res_o   = res_q;
  assign out_ctl_o   = ctl_q;
  assign out_dq_o    = dq_q;
  assign out_dvs_o   = dvs_q;

endmodule

`default_nettype wire

FILE: rtl/fpa_div_stage.sv
`default_nettype none

module fpa_div_stage #(
  parameter int unsigned OW = 32,
  parameter int unsigned QW = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OW-1:0]     res_i,
  input  wire fpa_pkg::fpa_ctl_t ctl_i,
  input  wire logic [QW-1:0]     dq_i,
  input  wire logic [OW-1:0]     rem_i,
  input  wire logic [OW-1:0]     dvs_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [OW-1:0]          res_o,
  output fpa_pkg::fpa_ctl_t      ctl_o,
  output logic [QW-1:0]          dq_o,
  output logic [OW-1:0]          rem_o,
  output logic [OW-1:0]          dvs_o
);
  import fpa_pkg::*;

  logic          v_q;
  logic [OW-1:0] res_q, rem_q, dvs_q;
  fpa_ctl_t      ctl_q;
  logic [QW-1:0] dq_q;
  logic [OW-1:0] trial;
  logic          ge;

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // one restoring step: bring in the next dividend bit, try the subtract
  assign trial = {rem_i[OW-2:0], dq_i[QW-1]};
  assign ge    = trial >= dvs_i;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_i;
      ctl_q <= ctl_i;
      dvs_q <= dvs_i;
      rem_q <= ge ? OW'(trial - dvs_i) : trial;
      dq_q  <= {dq_i[QW-2:0], ge};
    end
  end

  assign out_valid_o = v_q;
  assign res_o       = res_q;
  assign ctl_o       = ctl_q;
  assign dq_o        = dq_q;
  assign rem_o       = rem_q;
  assign dvs_o       = dvs_q;

endmodule

`default_nettype wire

FILE: rtl/fpa_back.sv
`default_nettype none

module fpa_back #(
  parameter int unsigned OW = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [OW-1:0]              res_i,
  input  wire fpa_pkg::fpa_ctl_t          ctl_i,
  input  wire logic [OW-1:0]              quot_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [fpa_pkg::ValueBits-1:0]   result_o,
  output logic                            cmp_o,
  output logic                            dz_o
);
  import fpa_pkg::*;

  logic                  v_q;
  logic [ValueBits-1:0]  result_q;
  logic                  cmp_q, dz_q;
  logic signed [OW-1:0]  final_val;

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // signed quotient for a divide by a nonzero divisor, else the result from the front
  always_comb begin
    final_val = res_i;
    if (ctl_i.is_div && !ctl_i.dz) begin
      final_val = ctl_i.neg ? OW'(-quot_i) : quot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= ValueBits'(final_val);
      cmp_q    <= ctl_i.cmp;
      dz_q     <= ctl_i.dz;
    end
  end

  assign out_valid_o = v_q;
  assign result_o    = result_q;
  assign cmp_o       = cmp_q;
  assign dz_o        = dz_q;

endmodule

`default_nettype wire

FILE: test/tb_fixed_point_alu_top.sv
`timescale 1ns / 1ps

module tb_fixed_point_alu_top;
  import fpa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency = 32 + FracBits + 4;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] command_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic compare_true_o;
  logic divide_by_zero_o;

  alu_result_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  longint unsigned cycle_count = 0;

  fixed_point_alu_top #(.FRAC_BITS(FracBits), .WORD_BITS(32)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predicted result of one command
  function automatic alu_result_t alu_predict(fpa_cmd_e cmd, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wide_a;
    logic signed [63:0] wide_b;
    logic signed [63:0] wide_q;
    r = '0;
    wide_a = a;
    wide_b = b;
    case (cmd)
      CmdAdd: r.value = a + b;
      CmdSub: r.value = a - b;
      CmdMul: begin
        // exact product then drop fraction bits toward zero
        wide_q = wide_a * wide_b;
        if (wide_q < 0) wide_q = -((-wide_q) >>> FracBits);
        else wide_q = wide_q >>> FracBits;
        r.value = wide_q[31:0];
      end
      CmdDiv: begin
        if (b == 0) r.dz = 1'b1;
        else begin
          wide_q = (wide_a <<< FracBits) / wide_b;
          r.value = wide_q[31:0];
        end
      end
      CmdGt: r.cmp = a > b;
      CmdGe: r.cmp = a >= b;
      CmdLt: r.cmp = a < b;
      CmdLe: r.cmp = a <= b;
      CmdEq: r.cmp = a == b;
      CmdNe: r.cmp = a != b;
      CmdMin: r.value = (a < b) ? a : b;
      CmdMax: r.value = (b < a) ? a : b;
      CmdInc: r.value = a + 1;
      CmdDec: r.value = a - 1;
      CmdFromInt: r.value = a <<< FracBits;
      default: begin
        wide_q = (wide_a < 0) ? -((-wide_a) >>> FracBits) : (wide_a >>> FracBits);
        r.value = wide_q[31:0];
      end
    endcase
    return r;
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_fixed_point_alu_top NOT OK");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item value=%h cmp=%b dz=%b", $time, result_value_o,
                 compare_true_o, divide_by_zero_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_value_o !== exp_r.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                   result_value_o);
          error_count++;
        end
        if (compare_true_o !== exp_r.cmp) begin
          $display("%0t: compare_true expected %b actual %b", $time, exp_r.cmp,
                   compare_true_o);
          error_count++;
        end
        if (divide_by_zero_o !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz,
                   divide_by_zero_o);
          error_count++;
        end
      end
    end
  end

  // send one item, with random idle cycles before it
  task automatic send_item(fpa_cmd_e cmd, logic signed [31:0] a, logic signed [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(alu_predict(cmd, a, b));
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(5))
      0: return $urandom_range(4);
      1: return -$urandom_range(4);
      2: return 32'h8000_0000 + $urandom_range(2);
      3: return 32'h7fff_ffff - $urandom_range(2);
      4: return $signed(($urandom_range(65535)) - 32768) <<< $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  // every command at the extremes, divide by zero and divide overflow
  task automatic test_directed();
    logic signed [31:0] edge_vals[5];
    edge_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 256};
    for (int c = 0; c < 16; c++) begin
      send_item(fpa_cmd_e'(c), edge_vals[c % 5], edge_vals[(c + 2) % 5]);
    end
    send_item(CmdDiv, 32'sh0000_1234, 0);
    send_item(CmdDiv, 32'sh8000_0000, 0);
    send_item(CmdDiv, 32'sh8000_0000, 1);
    send_item(CmdDiv, 32'sh8000_0000, -1);
    send_item(CmdMul, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CmdMul, -3, 1);
    send_item(CmdToInt, -1, 0);
    send_item(CmdEq, 32'sh7fff_ffff, 32'sh7fff_ffff);
    stop_sending();
    // hold off until the pipeline is empty
    drain_results();
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(fpa_cmd_e'($urandom_range(15)), random_operand(), random_operand());
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 13;
    recv_idle_pct = 61;
    test_directed();
    test_random(530);
    send_idle_pct = 61;
    recv_idle_pct = 13;
    test_random(530);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(530);
    stop_sending();
    drain_results();
    repeat (Latency + 10) @(negedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_fixed_point_alu_top OK");
    end else begin
      $display("tb_fixed_point_alu_top NOT OK");
    end
    $finish;
  end

endmodule
